@@ sv/stepper_homing_position_driver_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stepper homing driver
// Short wrappers for clocked concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef STEPPER_HOMING_POSITION_DRIVER_CORE_ASSERT_SVH
`define STEPPER_HOMING_POSITION_DRIVER_CORE_ASSERT_SVH

// Checked on every rising edge of clk, ignored while reset is asserted.
`define SHDRV_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define SHDRV_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/shdrv_pkg.sv @@
// ----------------------------------------------------------------------------
// Stepper homing driver package
// Shared types, register map and the full-step coil table.
// ----------------------------------------------------------------------------
package shdrv_pkg;

	// Width of the step interval register and its reset value.
	localparam int unsigned CFG_W = 10;
	localparam logic [CFG_W-1:0] STEP_INTERVAL_RESET = 10'd10;

	// APB register map.
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_STEP_INTERVAL = 3'd0;

	// Stream payload widths, padded to whole bytes.
	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 40;

	// One result item.
	typedef struct packed {
		logic              stepped;
		logic              homed;
		logic signed [31:0] position;
		logic [3:0]        coil_pattern;
	} res_t;

	// Full-step drive pattern for a given phase.
	function automatic logic [3:0] coil_lookup(input logic [1:0] phase);
		logic [3:0] pat;
		case (phase)
			2'd0: pat = 4'b1001;
			2'd1: pat = 4'b1100;
			2'd2: pat = 4'b0110;
			2'd3: pat = 4'b0011;
			default: pat = 4'b0000;
		endcase
		return pat;
	endfunction

endpackage

@@ sv/shdrv_core.sv @@
// ----------------------------------------------------------------------------
// Stepper homing driver step logic
// Holds the driver state and computes one tick's update and result.
// ----------------------------------------------------------------------------
`include "stepper_homing_position_driver_core_assert.svh"

module shdrv_core #(
	parameter int unsigned INTERVAL_WIDTH = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            limit_low,
	input  logic signed [31:0]              target_position,
	input  logic [shdrv_pkg::CFG_W-1:0]     step_interval,
	output shdrv_pkg::res_t                 res
);

	localparam int unsigned CMP_W =
		(INTERVAL_WIDTH > shdrv_pkg::CFG_W) ? INTERVAL_WIDTH : shdrv_pkg::CFG_W;

	logic                      homed_q;
	logic signed [31:0]        pos_q;
	logic [1:0]                phase_q;
	logic [INTERVAL_WIDTH-1:0] ticks_q;
	logic [3:0]                coil_q;

	logic [INTERVAL_WIDTH-1:0] ticks_inc;
	logic                      due;
	logic [1:0]                phase_dec;
	logic                      homed_n;
	logic signed [31:0]        pos_n;
	logic [1:0]                phase_n;
	logic [INTERVAL_WIDTH-1:0] ticks_n;
	logic [3:0]                coil_n;
	logic                      stepped;

	always_comb begin
		ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
		due       = CMP_W'(ticks_inc) >= CMP_W'(step_interval);
		phase_dec = phase_q - 2'd1;

		homed_n = homed_q;
		pos_n   = pos_q;
		phase_n = phase_q;
		ticks_n = ticks_inc;
		coil_n  = coil_q;
		stepped = 1'b0;

		if (!homed_q) begin
			if (!limit_low) begin
				// Home switch reached: zero the position, no step this tick.
				pos_n   = '0;
				homed_n = 1'b1;
			end else if (due) begin
				phase_n = phase_dec;
				coil_n  = shdrv_pkg::coil_lookup(phase_dec);
				ticks_n = '0;
				stepped = 1'b1;
			end
		end else if (due && (target_position != pos_q)) begin
			if (target_position > pos_q) begin
				pos_n = pos_q + 32'sd1;
			end else begin
				pos_n = pos_q - 32'sd1;
			end
			coil_n  = shdrv_pkg::coil_lookup(pos_n[1:0]);
			ticks_n = '0;
			stepped = 1'b1;
		end

		res.coil_pattern = coil_n;
		res.position     = pos_n;
		res.homed        = homed_n;
		res.stepped      = stepped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			homed_q <= 1'b0;
			pos_q   <= '0;
			phase_q <= '0;
			ticks_q <= '0;
			coil_q  <= '0;
		end else if (adv) begin
			homed_q <= homed_n;
			pos_q   <= pos_n;
			phase_q <= phase_n;
			ticks_q <= ticks_n;
			coil_q  <= coil_n;
		end
	end

	`SHDRV_ASSERT_CLK(a_homed_sticky, homed_q |=> homed_q, "homed flag dropped")
	`SHDRV_ASSERT_ALWAYS(a_pos_zero_unhomed, (!homed_q) |-> (pos_q == '0), "position moved before homing")
	`SHDRV_ASSERT_CLK(a_home_found, (adv && !homed_q && !limit_low) |=> (homed_q && pos_q == '0), "home not taken")
	`SHDRV_ASSERT_CLK(a_step_clears_ticks, (adv && stepped) |=> (ticks_q == '0), "tick count not cleared on step")

endmodule

@@ sv/stepper_homing_position_driver_core.sv @@
// ----------------------------------------------------------------------------
// Stepper homing position driver
// Full-step driver that homes on an active-low switch, then tracks a target.
// ----------------------------------------------------------------------------
// Path: an accepted tick item is held in stage 1, and its result in the result register.
// Throughput: one item per cycle while the sink takes results; the single step stage between the input
// register and the result register sets this rate.
// Reset: arst_n clears both stages, the state (not homed, position zero,
// coils off) and sets the step interval to 10 ticks.
module stepper_homing_position_driver_core #(
	parameter int unsigned INTERVAL_WIDTH = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Tick items in.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [0] limit_low, [32:1] target_position, [39:33] zero
	input  logic [shdrv_pkg::IN_TDATA_W-1:0]      s_tdata,
	// Result items out.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [3:0] coil_pattern, [35:4] position, [36] homed, [37] stepped, [39:38] zero
	output logic [shdrv_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// Register access.
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [shdrv_pkg::PADDR_W-1:0]         paddr,
	input  logic [shdrv_pkg::PDATA_W-1:0]         pwdata,
	output logic [shdrv_pkg::PDATA_W-1:0]         prdata,
	output logic                                  pready
);

	// Configuration register. Bits above the register width are dropped and
	// writes to any other address are ignored.
	logic [shdrv_pkg::CFG_W-1:0] step_interval_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_interval_q <= shdrv_pkg::STEP_INTERVAL_RESET;
		end else if (psel && penable && pwrite && pready &&
			(paddr == shdrv_pkg::ADDR_STEP_INTERVAL)) begin
			step_interval_q <= pwdata[shdrv_pkg::CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == shdrv_pkg::ADDR_STEP_INTERVAL) begin
			prdata = shdrv_pkg::PDATA_W'(step_interval_q);
		end
	end

	// Stage 1 holds the accepted tick item; the result stage holds the item
	// that waits for the sink. State updates when stage 1 moves into the
	// result stage, so the sink's stall holds everything behind it.
	logic               valid_s1;
	logic               limit_low_s1;
	logic signed [31:0] target_s1;
	logic               valid_s2;
	shdrv_pkg::res_t    res_s2;
	shdrv_pkg::res_t    res_next;
	logic               adv;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			limit_low_s1 <= s_tdata[0];
			target_s1    <= s_tdata[32:1];
		end
	end

	shdrv_core #(
		.INTERVAL_WIDTH (INTERVAL_WIDTH)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.limit_low       (limit_low_s1),
		.target_position (target_s1),
		.step_interval   (step_interval_q),
		.res             (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.stepped, res_s2.homed, res_s2.position,
		res_s2.coil_pattern};

endmodule
